### src/necir_pkg.sv
// necir_pkg: shared types, codes and constants for the nec ir edge capture decoder
// used by the capture unit, the top level and the port checker
`default_nettype none

package necir_pkg;

  // sizes and reset values
  localparam int PulseSlotsDefault = 64;
  localparam int CmdFirstSlot      = 17;
  localparam int CmdBits           = 8;
  localparam int TimeW             = 32;
  localparam int CfgDataW          = 16;
  localparam int CfgIdxW           = 1;

  localparam logic [CfgDataW-1:0] GapResetUs = 16'd20000;
  localparam logic [CfgDataW-1:0] OneResetUs = 16'd1000;

  // input kinds
  typedef enum logic {
    KindEdge = 1'b0,
    KindRead = 1'b1
  } kind_e;

  // read status codes
  typedef enum logic [1:0] {
    StatNone = 2'd0,
    StatBusy = 2'd1,
    StatCode = 2'd2
  } status_e;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgGapTimeout  = 1'b0,
    CfgOneThreshold = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic             kind;
    logic [TimeW-1:0] time_us;
    logic             level;
  } necir_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [CmdBits-1:0] code;
  } necir_out_t;

  typedef struct packed {
    logic [CfgDataW-1:0] gap_timeout_us;
    logic [CfgDataW-1:0] one_threshold_us;
  } necir_cfg_t;

endpackage

`default_nettype wire

### src/necir_capture.sv
// necir_capture: edge timing state, pulse count and command bit capture
// depends on necir_pkg
`default_nettype none

module necir_capture #(
  parameter int PULSE_SLOTS = necir_pkg::PulseSlotsDefault
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  take_i,
  input  wire necir_pkg::necir_in_t  item_i,
  input  wire necir_pkg::necir_cfg_t cfg_i,
  output necir_pkg::necir_out_t      res_o
);
  import necir_pkg::*;

  localparam int CntW = $clog2(PULSE_SLOTS + 1);
  localparam int CmdIdxW = $clog2(CmdBits);

  logic [TimeW-1:0]   last_edge_q, last_edge_d;
  logic [CntW-1:0]    count_q, count_d;
  logic [CmdBits-1:0] cmd_q, cmd_d;

  logic [TimeW-1:0]   dt;
  logic               gap_hit;
  logic               in_cmd_range;
  logic [CntW-1:0]    cmd_off;
  logic [CmdIdxW-1:0] cmd_idx;

  assign dt      = item_i.time_us - last_edge_q;
  assign gap_hit = dt >= TimeW'(cfg_i.gap_timeout_us);

  // only slots that land in the command byte are kept
  assign in_cmd_range = (count_q >= CntW'(CmdFirstSlot)) &&
                        (count_q < CntW'(CmdFirstSlot + CmdBits));
  assign cmd_off      = count_q - CntW'(CmdFirstSlot);
  assign cmd_idx      = cmd_off[CmdIdxW-1:0];

  always_comb begin
    res_o = '{status: StatNone, code: '0};
    if (count_q == '0) begin
      res_o.status = StatNone;
    end else if (dt <= TimeW'(cfg_i.gap_timeout_us)) begin
      res_o.status = StatBusy;
    end else begin
      res_o.status = StatCode;
      res_o.code   = cmd_q;
    end
  end

  always_comb begin
    last_edge_d = last_edge_q;
    count_d     = count_q;
    cmd_d       = cmd_q;
    if (take_i) begin
      if (item_i.kind == KindEdge) begin
        last_edge_d = item_i.time_us;
        if (!item_i.level) begin
          if (gap_hit) begin
            count_d = '0;
          end else if (count_q < CntW'(PULSE_SLOTS)) begin
            count_d = count_q + CntW'(1);
            if (in_cmd_range) begin
              cmd_d[cmd_idx] = dt > TimeW'(cfg_i.one_threshold_us);
            end
          end
        end
      end else if (res_o.status == StatCode) begin
        count_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_edge_q <= '0;
      count_q     <= '0;
      cmd_q       <= '0;
    end else begin
      last_edge_q <= last_edge_d;
      count_q     <= count_d;
      cmd_q       <= cmd_d;
    end
  end

endmodule

`default_nettype wire

### src/nec_ir_edge_capture_decoder_core.sv
// nec_ir_edge_capture_decoder_core: top level with config registers and result register
// depends on necir_pkg and necir_capture
//
// Takes one item (pin edge or read request) per clock unless the input stalls. An edge
// updates the capture state in the cycle it is accepted and gives no result; a read
// gives one result, shown on the output in the cycle after the transfer. The result
// register is the only stage, so input stall rises only while a result is held there
// and the output side stalls. All state comes out of reset ready; no clearing pass.
`default_nettype none

module nec_ir_edge_capture_decoder_core #(
  parameter int PULSE_SLOTS = necir_pkg::PulseSlotsDefault
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire necir_pkg::necir_in_t           in_item_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output necir_pkg::necir_out_t               out_item_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [necir_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [necir_pkg::CfgDataW-1:0] cfg_data_i
);
  import necir_pkg::*;

  necir_cfg_t cfg_q, cfg_d;
  logic       out_valid_q, out_valid_d;
  necir_out_t out_item_q, out_item_d;
  necir_out_t res;
  logic       take;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign take       = in_valid_i && !in_stall_o;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CfgGapTimeout:   cfg_d.gap_timeout_us   = cfg_data_i;
        CfgOneThreshold: cfg_d.one_threshold_us = cfg_data_i;
        default: ;
      endcase
    end
  end

  necir_capture #(
    .PULSE_SLOTS(PULSE_SLOTS)
  ) u_capture (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .item_i (in_item_i),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  // result register: load on a read transfer, drop once taken
  always_comb begin
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    if (take && in_item_i.kind == KindRead) begin
      out_valid_d = 1'b1;
      out_item_d  = res;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= '{gap_timeout_us: GapResetUs, one_threshold_us: OneResetUs};
      out_valid_q <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

### src/necir_checker.sv
// necir_checker: port level checks for nec_ir_edge_capture_decoder_core
// depends on necir_pkg; attached to the top level by bind
`default_nettype none

module necir_checker (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  in_valid_i,
  input wire logic                  in_stall_o,
  input wire necir_pkg::necir_in_t  in_item_i,
  input wire logic                  out_valid_o,
  input wire logic                  out_stall_i,
  input wire necir_pkg::necir_out_t out_item_o
);
  import necir_pkg::*;

  // a held result stays put while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  // every read transfer shows a result next cycle
  a_read_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_item_i.kind == KindRead |=> out_valid_o)
    else $error("read transfer gave no result");

  // an edge transfer never makes a result appear
  a_edge_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_item_i.kind == KindEdge &&
    !(out_valid_o && out_stall_i) |=> !out_valid_o)
    else $error("edge transfer gave a result");

  // input only stalls behind a held result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with output free");

  // code is zero unless the status says a code is there
  a_code_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status != StatCode |-> out_item_o.code == '0)
    else $error("code set without valid status");

endmodule

bind nec_ir_edge_capture_decoder_core necir_checker u_necir_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

`default_nettype wire
